// ===== rtl/core/double_ended_queue_macros.svh =====
// assertion macros shared by the double-ended queue rtl
// no dependencies; included by the modules that carry checks
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, disabled during reset
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// ===== rtl/core/dq_pkg.sv =====
// types, codes and ring index helpers for the double-ended queue
// no dependencies; used by dq_front, dq_back and double_ended_queue
package dq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request action codes
  localparam logic [2:0] ACT_PUSH_HEAD = 3'd0;
  localparam logic [2:0] ACT_PUSH_TAIL = 3'd1;
  localparam logic [2:0] ACT_POP_HEAD  = 3'd2;
  localparam logic [2:0] ACT_POP_TAIL  = 3'd3;
  localparam logic [2:0] ACT_DUMP_FWD  = 3'd4;
  localparam logic [2:0] ACT_DUMP_REV  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_HEAD,
    OP_PUSH_TAIL,
    OP_POP_HEAD,
    OP_POP_TAIL,
    OP_DUMP_FWD,
    OP_DUMP_REV,
    OP_NOP
  } dq_op_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } dq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic [CNT_W-1:0]   count;
    logic               last;
  } dq_out_t;

  typedef struct packed {
    dq_op_t             op;
    logic signed [31:0] value;
  } dq_cmd_t;

  function automatic dq_op_t decode_action(input logic [2:0] action);
    dq_op_t op;
    case (action)
      ACT_PUSH_HEAD: op = OP_PUSH_HEAD;
      ACT_PUSH_TAIL: op = OP_PUSH_TAIL;
      ACT_POP_HEAD:  op = OP_POP_HEAD;
      ACT_POP_TAIL:  op = OP_POP_TAIL;
      ACT_DUMP_FWD:  op = OP_DUMP_FWD;
      ACT_DUMP_REV:  op = OP_DUMP_REV;
      default:       op = OP_NOP;
    endcase
    return op;
  endfunction

  // position plus offset around the ring, offset at most CAPACITY
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] pos,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(pos) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] pos);
    logic [ADDR_W-1:0] r;
    if (pos == ADDR_W'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = pos + ADDR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] pos);
    logic [ADDR_W-1:0] r;
    if (pos == '0) begin
      r = ADDR_W'(CAPACITY - 1);
    end else begin
      r = pos - ADDR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/dq_front.sv =====
// front end: takes requests, decodes the action, holds them in a two-entry queue
// depends on dq_pkg
module dq_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dq_pkg::dq_in_t  in_data,
  output logic            cmd_valid,
  output dq_pkg::dq_cmd_t cmd,
  input  logic            cmd_take
);
  import dq_pkg::*;

  dq_cmd_t    q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload entries, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r].op    <= decode_action(in_data.action);
      q_r[wr_ptr_r].value <= in_data.value;
    end
  end

endmodule

// ===== rtl/core/dq_back.sv =====
// back end: ring store, head and count, pop refill and dump sequencing
// depends on dq_pkg and double_ended_queue_macros.svh
module dq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  input  dq_pkg::dq_cmd_t cmd,
  output logic            cmd_take,
  output logic            out_valid,
  input  logic            out_stall,
  output dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;
  `include "double_ended_queue_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DUMP = 3'b100
  } dq_state_t;

  dq_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [31:0] hv_r, hv_nxt;
  logic signed [31:0] tv_r, tv_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic               pop_head_r, pop_head_nxt;
  logic               dump_rev_r, dump_rev_nxt;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_r;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;

  logic               out_valid_r, out_valid_nxt;
  dq_out_t            out_data_r;
  dq_out_t            res;
  logic               load;
  logic               oready;
  logic [CNT_W-1:0]   idx_ext;
  logic               dump_last;
  logic               is_push;

  assign oready    = !out_valid_r || !out_stall;
  assign idx_ext   = CNT_W'(idx_r);
  assign dump_last = ((idx_ext + CNT_W'(1)) == count_r);
  assign is_push   = (cmd.op == OP_PUSH_HEAD) || (cmd.op == OP_PUSH_TAIL);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    hv_nxt       = hv_r;
    tv_nxt       = tv_r;
    idx_nxt      = idx_r;
    pop_head_nxt = pop_head_r;
    dump_rev_nxt = dump_rev_r;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    load         = 1'b0;
    cmd_take     = 1'b0;
    res          = '0;
    res.status   = ST_OK;
    res.last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && oready) begin
          cmd_take = 1'b1;
          case (cmd.op)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
              load = 1'b1;
              if (count_r == CAP_CNT) begin
                res.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (cmd.op == OP_PUSH_HEAD) begin
                  head_nxt = ring_dec(head_r);
                  wr_addr  = head_nxt;
                  hv_nxt   = cmd.value;
                  if (count_r == '0) begin
                    tv_nxt = cmd.value;
                  end
                end else begin
                  wr_addr = ring_add(head_r, count_r);
                  tv_nxt  = cmd.value;
                  if (count_r == '0) begin
                    hv_nxt = cmd.value;
                  end
                end
              end
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
              if (count_r == '0) begin
                load       = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (cmd.op == OP_POP_HEAD) begin
                  head_nxt = ring_inc(head_r);
                end
                if (count_r == CNT_W'(1)) begin
                  load = 1'b1;
                end else begin
                  // refill the cached end value from the store
                  rd_en        = 1'b1;
                  pop_head_nxt = (cmd.op == OP_POP_HEAD);
                  rd_addr      = (cmd.op == OP_POP_HEAD) ? head_nxt
                               : ring_add(head_r, count_r - CNT_W'(2));
                  state_nxt    = S_POP;
                end
              end
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
              if (count_r == '0) begin
                load       = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                rd_en        = 1'b1;
                idx_nxt      = '0;
                dump_rev_nxt = (cmd.op == OP_DUMP_REV);
                rd_addr      = (cmd.op == OP_DUMP_REV)
                             ? ring_add(head_r, count_r - CNT_W'(1)) : head_r;
                state_nxt    = S_DUMP;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        if (oready) begin
          load = 1'b1;
          if (pop_head_r) begin
            hv_nxt = rdata_r;
          end else begin
            tv_nxt = rdata_r;
          end
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (oready) begin
          load     = 1'b1;
          res.item = rdata_r;
          res.last = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + ADDR_W'(1);
            rd_en   = 1'b1;
            rd_addr = dump_rev_r
                    ? ring_add(head_r, count_r - idx_ext - CNT_W'(2))
                    : ring_add(head_r, idx_ext + CNT_W'(1));
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.count      = count_nxt;
    res.head_value = (count_nxt == '0) ? 32'sd0 : hv_nxt;
    res.tail_value = (count_nxt == '0) ? 32'sd0 : tv_nxt;
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // cached end values, dump and pop bookkeeping, result payload
  always_ff @(posedge clk) begin
    hv_r       <= hv_nxt;
    tv_r       <= tv_nxt;
    idx_r      <= idx_nxt;
    pop_head_r <= pop_head_nxt;
    dump_rev_r <= dump_rev_nxt;
    if (load) begin
      out_data_r <= res;
    end
  end

  // ring store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CAP_CNT)
  `DQ_ASSERT_IMPL(a_pop_out_free, clk, rst_n, state_r == S_POP, !out_valid_r)
  `DQ_ASSERT_IMPL(a_dump_nonempty, clk, rst_n, state_r == S_DUMP, count_r != '0)
  `DQ_ASSERT_NEXT(a_full_holds, clk, rst_n, cmd_take && is_push && count_r == CAP_CNT, count_r == CAP_CNT)

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// top level of the bounded double-ended queue of signed 32-bit values
// depends on dq_pkg, dq_front and dq_back
//
// usage
// - in channel: in_valid/in_stall with in_data (action, value); a request is
//   taken at a clock edge with in_valid high and in_stall low
// - out channel: out_valid/out_stall with out_data (status, item, head and
//   tail values, count, last); a result leaves at an edge with out_valid high
//   and out_stall low
// - path: a request is registered in the front queue, then in the result
//   register; a pop that leaves elements behind also passes through the
//   store read (the new end value is read back from the store)
// - pushes and short pops finish in S_IDLE, refilling pops also pass
//   through S_POP, a dump gives one result per cycle while out_stall is
//   low; the single read port of the ring store sets the dump pace
// - a two-entry request queue in front lets requests arrive while a dump
//   drains; in_stall rises when it is full
// - when out_stall is held on a valid result the result register keeps its
//   value and the back end waits; the front keeps taking requests until its queue fills
// - reset (rst_n low, synchronous) empties the queue and drops any pending
//   requests and results; the store contents are left as they are
module double_ended_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dq_pkg::dq_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dq_pkg::dq_out_t out_data
);
  import dq_pkg::*;

  // decoded request handed from front to back
  logic    cmd_valid;
  dq_cmd_t cmd;
  logic    cmd_take;

  // front: request intake and action decode
  dq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: ring store, head/count state and result register
  dq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/deque_checker.sv =====
// result checker for the double-ended queue: mirrors the ring, predicts results
// depends on dq_pkg for the request and result structs and the action/status codes
module deque_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  dq_pkg::dq_in_t  in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  dq_pkg::dq_out_t out_data,
  output int              mismatch_count,
  output int              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] mirror_ring [CAPACITY];
  logic [ADDR_W-1:0]  mirror_head;
  logic [CNT_W-1:0]   mirror_count;
  dq_out_t            expected_results [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic int ring_slot(input int off);
    return (int'(mirror_head) + off) % CAPACITY;
  endfunction

  // result as seen after the action, end values read 0 on an empty queue
  function automatic dq_out_t make_result(input logic [1:0] st, input logic signed [31:0] elem,
                                          input logic fin);
    dq_out_t r;
    r.status     = st;
    r.item       = elem;
    r.count      = mirror_count;
    r.last       = fin;
    r.head_value = '0;
    r.tail_value = '0;
    if (mirror_count != '0) begin
      r.head_value = mirror_ring[ring_slot(0)];
      r.tail_value = mirror_ring[ring_slot(int'(mirror_count) - 1)];
    end
    return r;
  endfunction

  task automatic apply_request(input dq_in_t req);
    int n;
    int off;
    n = int'(mirror_count);
    case (req.action)
      ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
        if (n >= CAPACITY) begin
          expected_results.push_back(make_result(ST_FULL, '0, 1'b1));
        end else begin
          if (req.action == ACT_PUSH_HEAD) begin
            mirror_head = ADDR_W'((int'(mirror_head) + CAPACITY - 1) % CAPACITY);
            mirror_ring[mirror_head] = req.value;
          end else begin
            mirror_ring[ring_slot(n)] = req.value;
          end
          mirror_count = mirror_count + 1'b1;
          expected_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      ACT_POP_HEAD, ACT_POP_TAIL: begin
        if (n == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          if (req.action == ACT_POP_HEAD) begin
            mirror_head = ADDR_W'(ring_slot(1));
          end
          mirror_count = mirror_count - 1'b1;
          expected_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_REV: begin
        if (n == 0) begin
          expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            off = (req.action == ACT_DUMP_FWD) ? i : n - 1 - i;
            expected_results.push_back(make_result(ST_OK, mirror_ring[ring_slot(off)],
                                                   i == n - 1));
          end
        end
      end
      default: begin
        expected_results.push_back(make_result(ST_OK, '0, 1'b1));
      end
    endcase
  endtask

  task automatic note_failure(input string what, input dq_out_t want, input dq_out_t got);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("deque check: %s at %0t", what, $realtime);
      $display("  exp status=%0d item=%0d head=%0d tail=%0d count=%0d last=%0d",
               want.status, want.item, want.head_value, want.tail_value, want.count,
               want.last);
      $display("  got status=%0d item=%0d head=%0d tail=%0d count=%0d last=%0d",
               got.status, got.item, got.head_value, got.tail_value, got.count, got.last);
    end
    mismatch_count++;
  endtask

  task automatic check_result(input dq_out_t got);
    dq_out_t want;
    if (expected_results.size() == 0) begin
      note_failure("result with nothing expected", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.status !== want.status || got.item !== want.item ||
          got.head_value !== want.head_value || got.tail_value !== want.tail_value ||
          got.count !== want.count || got.last !== want.last) begin
        note_failure("result mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      mirror_head  = '0;
      mirror_count = '0;
      foreach (mirror_ring[i]) mirror_ring[i] = '0;
      pending_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        apply_request(in_data);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

// ===== tb/sv/double_ended_queue_tb.sv =====
// testbench top for the double-ended queue: clock, reset, requests, backpressure
// depends on dq_pkg, double_ended_queue and deque_checker
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // action codes the block treats as no-ops
  localparam logic [2:0] ACT_RESERVED_LO = 3'd6;
  localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

  localparam int ITEM_TARGET  = 400;
  localparam int QUIET_ITEMS  = 60;       // final stretch with no idling at all
  localparam int DRAIN_CYCLES = 16;       // extra watch for stray results after the last expected one
  localparam int CYCLE_LIMIT  = 1200000;  // watchdog bound for the whole run

  typedef enum logic [1:0] {
    EP_FILL,
    EP_DRAIN,
    EP_MIXED
  } episode_t;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  dq_in_t  in_data   = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  dq_out_t out_data;

  int          mismatch_count;
  int          pending_count;
  int          requests_sent = 0;
  int          gap_pct       = 0;
  int          stall_pct     = 0;
  bit          quiet_tail    = 1'b0;
  int unsigned cycle_count   = 0;

  double_ended_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  deque_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[double_ended_queue] ERROR");
      $finish;
    end
  end

  // output backpressure: a free-running stretch, then maybe a stall burst
  initial begin
    int unsigned run_len;
    forever begin
      run_len = $urandom_range(1, 30);
      repeat (run_len) @(posedge clk);
      if (!quiet_tail && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // mostly random words, with the sign and all-ones/zero corners mixed in
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 15))
      0:       v = {1'b1, 31'b0};
      1:       v = {1'b0, {31{1'b1}}};
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // fill leans hard on pushes, drain on pops, mixed spreads over every code
  function automatic logic [2:0] pick_action(input episode_t mode);
    int r;
    logic [2:0] a;
    r = $urandom_range(0, 99);
    case (mode)
      EP_FILL: begin
        if (r < 45)      a = ACT_PUSH_HEAD;
        else if (r < 90) a = ACT_PUSH_TAIL;
        else if (r < 93) a = ACT_POP_HEAD;
        else if (r < 95) a = ACT_POP_TAIL;
        else if (r < 97) a = ACT_DUMP_FWD;
        else if (r < 99) a = ACT_DUMP_REV;
        else             a = ACT_RESERVED_HI;
      end
      EP_DRAIN: begin
        if (r < 45)      a = ACT_POP_HEAD;
        else if (r < 90) a = ACT_POP_TAIL;
        else if (r < 93) a = ACT_PUSH_HEAD;
        else if (r < 95) a = ACT_PUSH_TAIL;
        else if (r < 97) a = ACT_DUMP_FWD;
        else if (r < 99) a = ACT_DUMP_REV;
        else             a = ACT_RESERVED_LO;
      end
      default: begin
        case (r % 8)
          0:       a = ACT_PUSH_HEAD;
          1:       a = ACT_PUSH_TAIL;
          2:       a = ACT_POP_HEAD;
          3:       a = ACT_POP_TAIL;
          4:       a = ACT_DUMP_FWD;
          5:       a = ACT_DUMP_REV;
          6:       a = ACT_RESERVED_LO;
          default: a = ACT_RESERVED_HI;
        endcase
      end
    endcase
    return a;
  endfunction

  // one request: optional idle burst, then hold valid until the block takes it
  task automatic issue(input logic [2:0] act, input logic signed [31:0] val);
    if (!quiet_tail && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, value: val};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // no-op codes are noise and do not count toward the target
    if (act < ACT_RESERVED_LO) requests_sent++;
    quiet_tail = (requests_sent >= ITEM_TARGET - QUIET_ITEMS);
  endtask

  initial begin
    episode_t   mode;
    logic [2:0] act;
    int         progress;
    int         goal;
    bit         first_episode;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-queue corners, sign extremes at both ends, no-op codes
    gap_pct   = 30;
    stall_pct = 30;
    issue(ACT_POP_HEAD, '0);
    issue(ACT_POP_TAIL, '1);
    issue(ACT_DUMP_FWD, '0);
    issue(ACT_DUMP_REV, '0);
    issue(ACT_RESERVED_LO, '1);
    issue(ACT_PUSH_HEAD, {1'b1, 31'b0});
    issue(ACT_PUSH_TAIL, {1'b0, {31{1'b1}}});
    issue(ACT_PUSH_HEAD, '0);
    issue(ACT_PUSH_TAIL, '1);
    issue(ACT_DUMP_FWD, '0);
    issue(ACT_DUMP_REV, '1);
    issue(ACT_RESERVED_HI, 32'h5a5a_a5a5);
    issue(ACT_POP_HEAD, '0);
    issue(ACT_POP_TAIL, '0);
    issue(ACT_DUMP_FWD, '0);
    issue(ACT_POP_TAIL, '0);
    issue(ACT_POP_HEAD, '0);   // last element leaves, queue empty again
    issue(ACT_POP_HEAD, '0);
    issue(ACT_PUSH_TAIL, 32'h5555_5555);
    issue(ACT_PUSH_HEAD, 32'haaaa_aaaa);
    issue(ACT_DUMP_REV, '0);
    issue(ACT_POP_TAIL, '0);
    issue(ACT_POP_HEAD, '0);

    // random episodes: fill to full and past it, drain to empty and past it,
    // or a short uniform mix; the first one always fills
    first_episode = 1'b1;
    while (requests_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0, 1:    mode = EP_FILL;
        2, 3:    mode = EP_DRAIN;
        default: mode = EP_MIXED;
      endcase
      if (first_episode) mode = EP_FILL;
      first_episode = 1'b0;

      // idling intensity per episode, including stretches with none
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        default: stall_pct = 70;
      endcase

      // fill counts pushes, drain counts pops, so the ring reaches its limit
      goal     = (mode == EP_MIXED) ? $urandom_range(20, 60) : CAPACITY + 8;
      progress = 0;
      while (progress < goal && requests_sent < ITEM_TARGET) begin
        act = pick_action(mode);
        issue(act, pick_value());
        case (mode)
          EP_FILL:  if (act == ACT_PUSH_HEAD || act == ACT_PUSH_TAIL) progress++;
          EP_DRAIN: if (act == ACT_POP_HEAD || act == ACT_POP_TAIL) progress++;
          default:  progress++;
        endcase
      end
    end

    in_valid <= 1'b0;

    // first let the checker queue the final request's results,
    // then let every expected result arrive and watch a little longer for strays
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule
